@@ hw/rtl/skf_pkg.sv @@
// Shared types and constants for the scalar Kalman filter core.
// Used by the controller, the datapath and the top level; no dependencies.
package skf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned MeasW    = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegInitEst = 2'd0;
  localparam logic [CfgAddrW-1:0] RegInitVar = 2'd1;
  localparam logic [CfgAddrW-1:0] RegProcQ   = 2'd2;
  localparam logic [CfgAddrW-1:0] RegMeasR   = 2'd3;

  localparam logic [DataW-1:0] InitEstRst = 32'h0000_0000;
  localparam logic [DataW-1:0] InitVarRst = 32'h0001_0000;
  localparam logic [DataW-1:0] ProcQRst   = 32'h0000_028F;
  localparam logic [DataW-1:0] MeasRRst   = 32'h0001_0000;

  localparam logic [GainW-1:0] GainMax = 16'hFFFF;

  typedef struct packed {
    logic start;     // capture sample, predict variance, seed divider
    logic div_step;  // one restoring division step
    logic mul;       // register both products
    logic update;    // commit state and present the result
  } skf_cmd_t;

  typedef struct packed {
    logic div_done;  // current step is the last quotient bit
    logic out_free;  // output register can take a new result
  } skf_status_t;

endpackage

@@ hw/rtl/skf_if.sv @@
// Valid/ready channel interfaces for the scalar Kalman filter core.
// Sample channel in, result channel out; no dependencies.
interface skf_meas_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface skf_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  logic        [31:0] variance;

  modport source (output valid, output estimate, output variance, input ready);
  modport sink (input valid, input estimate, input variance, output ready);
endinterface

@@ hw/rtl/skf_ctrl.sv @@
// Sequencing state machine of the scalar Kalman filter core.
// Depends on skf_pkg for the command and status structs.
module skf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  skf_pkg::skf_status_t status_i,
  output skf_pkg::skf_cmd_t    cmd_o
);
  import skf_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StMul,
    StUpd
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = (state_q == StIdle) && in_valid_i;
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.mul      = (state_q == StMul);
    cmd_o.update   = (state_q == StUpd) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (status_i.div_done) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StUpd;
        end
        StUpd: begin
          // hold until the previous result has been taken
          if (status_i.out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StDiv))
    else $error("accepted request did not start the division");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.div_step, cmd_o.mul, cmd_o.update}))
    else $error("more than one datapath command at once");

  a_update_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> in_ready_o)
    else $error("controller not idle after commit");

endmodule

@@ hw/rtl/skf_dp.sv @@
// Datapath of the scalar Kalman filter core: configuration, state,
// restoring divider, multipliers and output register. Depends on skf_pkg.
module skf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [skf_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [skf_pkg::DataW-1:0]     cfg_wdata_i,
  input  logic signed [skf_pkg::MeasW-1:0] measurement_i,
  input  skf_pkg::skf_cmd_t             cmd_i,
  output skf_pkg::skf_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [skf_pkg::DataW-1:0] estimate_o,
  output logic [skf_pkg::DataW-1:0]     variance_o
);
  import skf_pkg::*;

  logic [DataW-1:0] init_est_q, init_var_q, q_q, r_q;
  logic [DataW-1:0] est_q, var_q;

  logic [DataW-1:0]   p_q;
  logic [DataW:0]     den_q;
  logic [DataW:0]     rem_q;
  logic [GainW-1:0]   quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic               r_zero_q;
  logic signed [33:0] e_q;

  logic signed [50:0] prod_c_q;
  logic [48:0]        prod_v_q;

  logic               out_valid_q;
  logic [DataW-1:0]   out_est_q, out_var_q;

  // prediction and residual
  logic [DataW:0]     p_sum;
  logic [DataW-1:0]   p_sat;
  logic signed [33:0] e_d;
  assign p_sum = {1'b0, var_q} + {1'b0, q_q};
  assign p_sat = p_sum[DataW] ? '1 : p_sum[DataW-1:0];
  assign e_d   = $signed({{2{measurement_i[MeasW-1]}}, measurement_i, 16'h0000})
               - $signed({{2{est_q[DataW-1]}}, est_q});

  // restoring division step
  logic [DataW+1:0] rem_sh;
  logic             q_bit;
  assign rem_sh = {rem_q, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, den_q});

  // gain and products
  logic [GainW-1:0]   gain;
  logic [GainW:0]     one_minus_g;
  logic signed [50:0] prod_c_d;
  logic [48:0]        prod_v_d;
  assign gain = r_zero_q ? ((p_q == '0) ? '0 : GainMax) : quo_q;
  assign one_minus_g = 17'h1_0000 - {1'b0, gain};
  assign prod_c_d = $signed({1'b0, gain}) * e_q;
  assign prod_v_d = 49'(p_q) * 49'(one_minus_g);

  // update and saturation
  logic signed [34:0] corr;
  logic signed [35:0] est_sum;
  logic [DataW-1:0]   est_new, var_new;
  assign corr    = prod_c_q[50:16];
  assign est_sum = $signed({{4{est_q[DataW-1]}}, est_q}) + $signed({corr[34], corr});
  always_comb begin
    if (est_sum > 36'sh0_7FFF_FFFF) begin
      est_new = 32'h7FFF_FFFF;
    end else if (est_sum < -36'sh0_8000_0000) begin
      est_new = 32'h8000_0000;
    end else begin
      est_new = est_sum[DataW-1:0];
    end
  end
  assign var_new = prod_v_q[47:16];

  assign status_o.div_done = (cnt_q == DivCntW'(DivSteps - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign estimate_o  = $signed(out_est_q);
  assign variance_o  = out_var_q;

  // configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_est_q <= InitEstRst;
      init_var_q <= InitVarRst;
      q_q        <= ProcQRst;
      r_q        <= MeasRRst;
      est_q      <= InitEstRst;
      var_q      <= InitVarRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegInitEst: begin
          init_est_q <= cfg_wdata_i;
          est_q      <= cfg_wdata_i;
          var_q      <= init_var_q;
        end
        RegInitVar: begin
          init_var_q <= cfg_wdata_i;
          est_q      <= init_est_q;
          var_q      <= cfg_wdata_i;
        end
        RegProcQ: q_q <= cfg_wdata_i;
        RegMeasR: r_q <= cfg_wdata_i;
        default: ;
      endcase
    end else if (cmd_i.update) begin
      est_q <= est_new;
      var_q <= var_new;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      p_q      <= p_sat;
      den_q    <= {1'b0, p_sat} + {1'b0, r_q};
      rem_q    <= {1'b0, p_sat};
      quo_q    <= '0;
      r_zero_q <= (r_q == '0);
      e_q      <= e_d;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[DataW:0];
      quo_q <= {quo_q[GainW-2:0], q_bit};
    end
    if (cmd_i.mul) begin
      prod_c_q <= prod_c_d;
      prod_v_q <= prod_v_d;
    end
    if (cmd_i.update) begin
      out_est_q <= est_new;
      out_var_q <= var_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_var_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (var_new <= p_q))
    else $error("posterior variance above predicted variance");

  a_div_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && (r_q != '0)) |=> (rem_q < den_q))
    else $error("divider seeded with remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

@@ hw/rtl/scalar_kalman_filter_core.sv @@
// Top level of the scalar Kalman filter core: controller plus datapath.
// Depends on skf_pkg, skf_if, skf_ctrl and skf_dp.
//
// One-dimensional Kalman filter with A = H = 1 in Q16.16 fixed point. Each
// accepted sample request runs in order: the accepting edge predicts the
// variance and forms the residual, then the restoring divider forms the
// Q0.16 gain (one quotient bit per cycle), then the two multiplies are
// registered, and the commit, which waits until the result channel is free,
// presents the result. The core takes one sample at a time and accepts no new
// sample until the commit; a finished result waits in its own output
// register, so the next sample is accepted while it waits.
// Writing initial_estimate or initial_variance reloads both state values;
// configuration must be written only while no sample is in progress; the
// core does not enforce this.
module scalar_kalman_filter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [skf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [skf_pkg::DataW-1:0]    cfg_wdata_i,
  skf_meas_if.sink                     meas_if,
  skf_res_if.source                    res_if
);
  import skf_pkg::*;

  skf_cmd_t    cmd;
  skf_status_t status;

  skf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (meas_if.valid),
    .in_ready_o (meas_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  skf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .measurement_i (meas_if.measurement),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (res_if.valid),
    .out_ready_i   (res_if.ready),
    .estimate_o    (res_if.estimate),
    .variance_o    (res_if.variance)
  );

endmodule
